// File: rtl/core/char_lcd_request_sequencer_assert.svh
// Assertion macros for the character LCD request sequencer.
// Included by the top level; no other dependencies.
`ifndef CHAR_LCD_REQUEST_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_REQUEST_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CLRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CLRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/clrs_pkg.sv
// Shared types, codes and constants for the character LCD request sequencer.
// No dependencies; compiled first.
`default_nettype none

package clrs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_STRING_DEF  = 16;

    // Field widths of the request and result beats
    localparam int CMD_W    = 3;
    localparam int ROW_W    = 2;
    localparam int COL_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int DONE_W   = 3;

    // APB register file
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [7:0] TICK_PERIOD_RST = 8'd2;
    localparam logic [7:0] POWER_WAIT_RST  = 8'd30;

    // HD44780 command bytes
    localparam logic [7:0] LCD_FUNC_SET   = 8'h38;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0F;
    localparam logic [7:0] LCD_CLS        = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] LCD_LINE2_OFS  = 8'h40;

    localparam logic [4:0] MAX_COLUMN = 5'd16;
    localparam logic [2:0] INIT_STEPS = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_INIT  = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_POS   = 3'd3,
        CMD_CHAR  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED   = 2'd0,
        ST_REJECTED = 2'd1,
        ST_DROPPED  = 2'd2
    } t_status;

    typedef enum logic [DONE_W-1:0] {
        DONE_NONE   = 3'd0,
        DONE_INIT   = 3'd1,
        DONE_CLEAR  = 3'd2,
        DONE_POS    = 3'd3,
        DONE_STRING = 3'd4
    } t_done;

    typedef enum logic [1:0] {
        MODE_INIT     = 2'd0,
        MODE_OPER     = 2'd1,
        MODE_INACTIVE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ET_CHAR   = 2'd0,
        ET_CLEAR  = 2'd1,
        ET_POS    = 2'd2,
        ET_FINISH = 2'd3
    } t_etype;

    typedef enum logic [0:0] {
        REG_TICK_PERIOD = 1'b0,
        REG_POWER_WAIT  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic              row;
        logic              last;
        logic [CHAR_W-1:0] ch;
        t_etype            etype;
    } t_entry;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [7:0] data;
    } t_pins;

    typedef struct packed {
        t_status status;
        t_pins   pins;
        t_done   done;
    } t_result;

    function automatic logic [7:0] init_cmd(input logic [1:0] step);
        logic [7:0] b;
        case (step)
            2'd0:    b = LCD_FUNC_SET;
            2'd1:    b = LCD_DISP_ON;
            2'd2:    b = LCD_CLS;
            default: b = LCD_ENTRY_MODE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/clrs_if.sv
// Valid/ready channel interfaces: request beats in, result beats out.
// Depends on clrs_pkg for field widths.
`default_nettype none

interface clrs_req_if import clrs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] char_byte;
    logic              last_char;

    modport source (output valid, command, row, column, char_byte, last_char, input ready);
    modport sink   (input valid, command, row, column, char_byte, last_char, output ready);
endinterface

interface clrs_rsp_if import clrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                lcd_rs;
    logic                lcd_enable;
    logic [7:0]          lcd_data;
    logic [DONE_W-1:0]   done_event;

    modport source (output valid, status, lcd_rs, lcd_enable, lcd_data, done_event,
                    input ready);
    modport sink   (input valid, status, lcd_rs, lcd_enable, lcd_data, done_event,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/char_lcd_request_sequencer.sv
// Character LCD request sequencer: request ring, init/operate sequencing, APB regs.
// Depends on clrs_pkg, clrs_if and char_lcd_request_sequencer_assert.svh.
//
//   channel | dir | handshake     | beat
//   i_req   | in  | valid/ready   | command, row, column, char_byte, last_char
//   o_rsp   | out | valid/ready   | status, lcd_rs, lcd_enable, lcd_data, done_event
//   apb     | in  | psel/penable  | tick_period_ms @0x0, power_on_wait_ms @0x4
//
// One beat per cycle while i_req is ready: each request beat is decoded and
// applied to the ring and sequencer state, its result registered in the same cycle.
// The result side is a two-deep buffer (output register plus skid), so i_req
// stays ready while one result waits; ready drops only when both are full.
// The ring head is registered from the slot memory at the next read index, with a
// bypass when the slot being written is the one about to be read.
// Synchronous active-low reset clears control state; slot contents are not reset.
`default_nettype none

module char_lcd_request_sequencer import clrs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_STRING  = MAX_STRING_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    clrs_req_if.sink               i_req,
    clrs_rsp_if.source             o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SCW = $clog2(MAX_STRING + 1);

    function automatic logic [QW-1:0] next_idx(input logic [QW-1:0] i);
        return (i == QW'(QUEUE_DEPTH - 1)) ? '0 : i + QW'(1);
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0] r_tick_period;
    logic [7:0] r_power_wait;
    t_reg_idx   cfg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RST;
            r_power_wait  <= POWER_WAIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TICK_PERIOD: r_tick_period <= pwdata[7:0];
                REG_POWER_WAIT:  r_power_wait  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TICK_PERIOD: prdata = {{(CFG_DW-8){1'b0}}, r_tick_period};
            REG_POWER_WAIT:  prdata = {{(CFG_DW-8){1'b0}}, r_power_wait};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_entry                 r_mem [QUEUE_DEPTH];
    t_entry                 r_head;            // mirror of r_mem[r_ri]
    logic [QUEUE_DEPTH-1:0] r_busy, n_busy;
    logic [QUEUE_DEPTH-1:0] r_fin, n_fin;      // last char sent, slot now reports done
    logic [QW-1:0]          r_wi, n_wi;
    logic [QW-1:0]          r_ri, n_ri;
    t_mode                  r_mode, n_mode;
    logic [2:0]             r_init_step, n_init_step;
    logic                   r_phase, n_phase;  // 1: enable-low step next
    logic [15:0]            r_elapsed, n_elapsed;
    logic [SCW-1:0]         r_str_cnt, n_str_cnt;
    t_pins                  r_pins, n_pins;

    // Result buffer
    t_result r_out, r_skid, n_res;
    logic    r_out_v, r_skid_v;

    logic    accept;
    t_cmd    cmd;
    logic    init_req;
    logic    init_fin;
    logic    mem_we;
    t_entry  mem_wdata;
    logic    enq_req;
    t_entry  enq_entry;
    logic    retire;
    t_etype  head_type;
    logic [16:0] elapsed_sum;
    logic [15:0] elapsed_sat;

    assign i_req.ready = !r_skid_v;
    assign accept      = i_req.valid && i_req.ready;
    assign cmd         = t_cmd'(i_req.command);
    assign init_req    = accept && (cmd == CMD_INIT);
    assign init_fin    = accept && (cmd == CMD_TICK) && (r_mode == MODE_INIT)
                         && (r_init_step >= INIT_STEPS);

    assign head_type   = r_fin[r_ri] ? ET_FINISH : r_head.etype;
    assign elapsed_sum = {1'b0, r_elapsed} + {9'b0, r_tick_period};
    assign elapsed_sat = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];

    // ---------------------------------------------------------------
    // Mode: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_INACTIVE: begin
                if (init_req) n_mode = MODE_INIT;
            end
            MODE_INIT: begin
                if (init_fin) n_mode = MODE_OPER;
            end
            MODE_OPER: begin
                if (init_req) n_mode = MODE_INIT;
            end
            default: n_mode = MODE_INACTIVE;
        endcase
    end

    // ---------------------------------------------------------------
    // Per-beat datapath: ring, sequencer and pin updates, result
    // ---------------------------------------------------------------
    always_comb begin
        n_busy      = r_busy;
        n_fin       = r_fin;
        n_wi        = r_wi;
        n_ri        = r_ri;
        n_init_step = r_init_step;
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_str_cnt   = r_str_cnt;
        n_pins      = r_pins;
        n_res       = '{status: ST_QUEUED, pins: '0, done: DONE_NONE};
        enq_req     = 1'b0;
        enq_entry   = '{column: '0, row: 1'b0, last: 1'b0, ch: '0, etype: ET_CLEAR};
        retire      = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = enq_entry;

        if (accept) begin
            unique case (cmd)
                CMD_TICK: begin
                    if (r_mode == MODE_INIT) begin
                        n_elapsed = elapsed_sat;
                        if (r_init_step >= INIT_STEPS) begin
                            retire     = 1'b1;
                            n_res.done = DONE_INIT;
                        end else if (r_init_step == 3'd0
                                     && elapsed_sat < {8'b0, r_power_wait}) begin
                            // still in the power-on wait
                        end else if (!r_phase) begin
                            n_pins  = '{rs: 1'b0, en: 1'b1, data: init_cmd(r_init_step[1:0])};
                            n_phase = 1'b1;
                        end else begin
                            n_pins.en   = 1'b0;
                            n_phase     = 1'b0;
                            n_init_step = r_init_step + 3'd1;
                        end
                    end else if (r_mode == MODE_OPER && r_busy[r_ri]) begin
                        if (head_type == ET_FINISH) begin
                            retire     = 1'b1;
                            n_res.done = DONE_STRING;
                        end else if (!r_phase) begin
                            n_phase = 1'b1;
                            case (head_type)
                                ET_CHAR:  n_pins = '{rs: 1'b1, en: 1'b1, data: r_head.ch};
                                ET_CLEAR: n_pins = '{rs: 1'b0, en: 1'b1, data: LCD_CLS};
                                default:  n_pins = '{rs: 1'b0, en: 1'b1,
                                                     data: LCD_SET_DDRAM
                                                         + (r_head.row ? LCD_LINE2_OFS : 8'h00)
                                                         + {3'b0, r_head.column}};
                            endcase
                        end else begin
                            n_pins.en = 1'b0;
                            n_phase   = 1'b0;
                            case (head_type)
                                ET_CHAR: begin
                                    // last char turns its slot into a done report
                                    if (r_head.last) n_fin[r_ri] = 1'b1;
                                    else             retire      = 1'b1;
                                end
                                ET_CLEAR: begin
                                    retire     = 1'b1;
                                    n_res.done = DONE_CLEAR;
                                end
                                default: begin
                                    retire     = 1'b1;
                                    n_res.done = DONE_POS;
                                end
                            endcase
                        end
                    end
                end
                CMD_INIT: begin
                    // drop everything queued, hold the write slot without filling it
                    n_busy       = '0;
                    n_busy[r_wi] = 1'b1;
                    n_wi         = next_idx(r_wi);
                end
                CMD_CLEAR: begin
                    enq_req = 1'b1;
                end
                CMD_POS: begin
                    if (i_req.row > 2'd1 || i_req.column > MAX_COLUMN) begin
                        n_res.status = ST_REJECTED;
                    end else begin
                        enq_req   = 1'b1;
                        enq_entry = '{column: i_req.column, row: i_req.row[0], last: 1'b0,
                                      ch: '0, etype: ET_POS};
                    end
                end
                CMD_CHAR: begin
                    if (r_str_cnt >= SCW'(MAX_STRING)) begin
                        n_res.status = ST_REJECTED;
                    end else begin
                        enq_req   = 1'b1;
                        enq_entry = '{column: '0, row: 1'b0, last: i_req.last_char,
                                      ch: i_req.char_byte, etype: ET_CHAR};
                    end
                end
                default: ;
            endcase

            if (enq_req) begin
                if (r_busy[r_wi]) begin
                    n_res.status = ST_DROPPED;
                end else begin
                    mem_we       = 1'b1;
                    mem_wdata    = enq_entry;
                    n_busy[r_wi] = 1'b1;
                    n_fin[r_wi]  = 1'b0;
                    n_wi         = next_idx(r_wi);
                end
            end

            if (cmd == CMD_CHAR) begin
                if (i_req.last_char) n_str_cnt = '0;
                else if (mem_we)     n_str_cnt = r_str_cnt + SCW'(1);
            end

            if (retire) begin
                n_busy[r_ri] = 1'b0;
                n_ri         = next_idx(r_ri);
            end
        end

        n_res.pins = n_pins;
    end

    // ---------------------------------------------------------------
    // Slot memory with prefetched head
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_wi] <= mem_wdata;
        if (mem_we && r_wi == n_ri) r_head <= mem_wdata;
        else                        r_head <= r_mem[n_ri];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_fin       <= '0;
            r_wi        <= '0;
            r_ri        <= '0;
            r_mode      <= MODE_INACTIVE;
            r_init_step <= '0;
            r_phase     <= 1'b0;
            r_elapsed   <= '0;
            r_str_cnt   <= '0;
            r_pins      <= '0;
        end else begin
            r_busy      <= n_busy;
            r_fin       <= n_fin;
            r_wi        <= n_wi;
            r_ri        <= n_ri;
            r_mode      <= n_mode;
            r_init_step <= n_init_step;
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_str_cnt   <= n_str_cnt;
            r_pins      <= n_pins;
        end
    end

    // ---------------------------------------------------------------
    // Result buffer: output register plus skid
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (accept) begin
            if (!r_out_v || o_rsp.ready) r_out_v  <= 1'b1;
            else                         r_skid_v <= 1'b1;
        end else if (r_out_v && o_rsp.ready) begin
            if (r_skid_v) r_skid_v <= 1'b0;
            else          r_out_v  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_v || o_rsp.ready) r_out  <= n_res;
            else                         r_skid <= n_res;
        end else if (r_out_v && o_rsp.ready && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.lcd_rs     = r_out.pins.rs;
    assign o_rsp.lcd_enable = r_out.pins.en;
    assign o_rsp.lcd_data   = r_out.pins.data;
    assign o_rsp.done_event = r_out.done;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "char_lcd_request_sequencer_assert.svh"

    `CLRS_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid full, output empty")
    `CLRS_ASSERT_NEXT(a_init_one_slot, i_clk, i_rst_n, init_req, $onehot(r_busy) && (r_mode == MODE_INIT), "init did not leave one busy slot")
    `CLRS_ASSERT_SAME(a_step_bound, i_clk, i_rst_n, 1'b1, r_init_step <= INIT_STEPS, "init step past end")
    `CLRS_ASSERT_NEXT(a_idle_pins, i_clk, i_rst_n, accept && (cmd != CMD_TICK), $stable(r_pins), "request moved the pins")

endmodule

`default_nettype wire

// File: bench/tb_char_lcd_request_sequencer.sv
// Testbench for the character LCD request sequencer: random and directed request/tick
// beats, checked beat by beat against a behavioral model of the ring and the LCD pins.
// Depends on clrs_pkg, clrs_if and the char_lcd_request_sequencer RTL.

module tb_char_lcd_request_sequencer import clrs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int STALL_LIMIT     = 4000;   // cycles with no beat on either channel
    localparam int HOLD_CYCLES     = 300;    // long sink stall for the backpressure test
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 8;
    localparam int PRINT_CAP       = 40;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int RING_DEPTH      = QUEUE_DEPTH_DEF;
    localparam int STRING_MAX      = MAX_STRING_DEF;
    localparam int REG_STRIDE      = 4;
    localparam int ROW_MAX_OK      = 1;
    localparam int ELAPSED_MAX     = 16'hFFFF;

    // Command codes past CMD_CHAR are unused; the block must ignore them
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // ------------------------------------------------------------------
    // Clock, reset, APB and the two channels
    // ------------------------------------------------------------------
    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [CFG_DW-1:0] pwdata  = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    clrs_req_if req_if();
    clrs_rsp_if rsp_if();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    char_lcd_request_sequencer #(
        .QUEUE_DEPTH(RING_DEPTH),
        .MAX_STRING (STRING_MAX)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // ------------------------------------------------------------------
    // Model state: ring, sequencer and pins, plus the config registers
    // ------------------------------------------------------------------
    t_entry     slot_mem  [RING_DEPTH] = '{default: '0};
    logic       slot_busy [RING_DEPTH] = '{default: 1'b0};
    int         wr_ptr          = 0;
    int         rd_ptr          = 0;
    t_mode      lcd_mode        = MODE_INACTIVE;
    int         power_up_step   = 0;
    logic       en_low_next     = 1'b0;   // 0: next tick raises enable, 1: lowers it
    int         elapsed_ms      = 0;
    int         chars_in_string = 0;
    t_pins      lcd_pins        = '0;
    logic [7:0] tick_ms         = TICK_PERIOD_RST;
    logic [7:0] wait_ms         = POWER_WAIT_RST;
    logic [7:0] power_up_bytes [4] = '{LCD_FUNC_SET, LCD_DISP_ON, LCD_CLS, LCD_ENTRY_MODE};

    t_result awaited_outcomes [$];

    // Stimulus and bookkeeping
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int str_target   = 5;
    int str_pos      = 0;
    int fail_count   = 0;
    int stall_count  = 0;

    function automatic int ring_next(int p);
        return (p >= RING_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic void ring_retire();
        slot_busy[rd_ptr] = 1'b0;
        rd_ptr = ring_next(rd_ptr);
    endfunction

    function automatic t_status ring_push(t_entry e);
        if (slot_busy[wr_ptr])
            return ST_DROPPED;
        slot_mem[wr_ptr]  = e;
        slot_busy[wr_ptr] = 1'b1;
        wr_ptr = ring_next(wr_ptr);
        return ST_QUEUED;
    endfunction

    function automatic void pins_drive(logic rs, logic [7:0] data);
        lcd_pins = '{rs: rs, en: 1'b1, data: data};
    endfunction

    // One tick in init mode: power-on wait, four command bytes over two ticks each,
    // then the done tick. The step counter is never rewound, so a later init
    // finishes on its first tick.
    function automatic t_done power_up_tick();
        elapsed_ms = elapsed_ms + tick_ms;
        if (elapsed_ms > ELAPSED_MAX)
            elapsed_ms = ELAPSED_MAX;
        if (power_up_step >= INIT_STEPS) begin
            lcd_mode = MODE_OPER;
            ring_retire();
            return DONE_INIT;
        end
        if (power_up_step == 0 && elapsed_ms < wait_ms)
            return DONE_NONE;
        if (!en_low_next) begin
            pins_drive(1'b0, power_up_bytes[power_up_step]);
            en_low_next = 1'b1;
        end else begin
            lcd_pins.en = 1'b0;
            en_low_next = 1'b0;
            power_up_step++;
        end
        return DONE_NONE;
    endfunction

    // One tick in operational mode, working on the slot at the read pointer.
    // A last character turns into a finish entry that reports on the next tick.
    function automatic t_done ring_tick();
        t_entry e;
        if (!slot_busy[rd_ptr])
            return DONE_NONE;
        e = slot_mem[rd_ptr];
        if (e.etype == ET_FINISH) begin
            ring_retire();
            return DONE_STRING;
        end
        if (!en_low_next) begin
            case (e.etype)
                ET_CHAR:  pins_drive(1'b1, e.ch);
                ET_CLEAR: pins_drive(1'b0, LCD_CLS);
                default:  pins_drive(1'b0, LCD_SET_DDRAM + (e.row ? LCD_LINE2_OFS : 8'h00)
                                           + 8'(e.column));
            endcase
            en_low_next = 1'b1;
            return DONE_NONE;
        end
        lcd_pins.en = 1'b0;
        en_low_next = 1'b0;
        if (e.etype == ET_CHAR) begin
            if (e.last) begin
                e.etype = ET_FINISH;
                slot_mem[rd_ptr] = e;
            end else begin
                ring_retire();
            end
            return DONE_NONE;
        end
        ring_retire();
        if (e.etype == ET_CLEAR)
            return DONE_CLEAR;
        return DONE_POS;
    endfunction

    // Expected result beat for one accepted request beat
    function automatic t_result predict_lcd_outcome(logic [CMD_W-1:0] cmd,
            logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic [CHAR_W-1:0] ch, logic last);
        t_result r;
        t_entry  e;
        r.status = ST_QUEUED;
        r.done   = DONE_NONE;
        e = '0;
        case (cmd)
            CMD_TICK: begin
                if (lcd_mode == MODE_INIT)
                    r.done = power_up_tick();
                else if (lcd_mode == MODE_OPER)
                    r.done = ring_tick();
            end
            CMD_INIT: begin
                // never dropped: flags cleared, write slot claimed but not written
                foreach (slot_busy[i])
                    slot_busy[i] = 1'b0;
                lcd_mode = MODE_INIT;
                slot_busy[wr_ptr] = 1'b1;
                wr_ptr = ring_next(wr_ptr);
            end
            CMD_CLEAR: begin
                e.etype = ET_CLEAR;
                r.status = ring_push(e);
            end
            CMD_POS: begin
                if (row > ROW_MAX_OK || col > MAX_COLUMN) begin
                    r.status = ST_REJECTED;
                end else begin
                    e.etype  = ET_POS;
                    e.row    = row[0];
                    e.column = col;
                    r.status = ring_push(e);
                end
            end
            CMD_CHAR: begin
                if (chars_in_string >= STRING_MAX) begin
                    r.status = ST_REJECTED;
                end else begin
                    e.etype = ET_CHAR;
                    e.ch    = ch;
                    e.last  = last;
                    r.status = ring_push(e);
                    if (r.status == ST_QUEUED && !last)
                        chars_in_string++;
                end
                // a rejected or dropped last character still closes the string
                if (last)
                    chars_in_string = 0;
            end
            default: ;
        endcase
        r.pins = lcd_pins;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking: predict on every request beat, compare on every result beat
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                awaited_outcomes.push_back(predict_lcd_outcome(req_if.command, req_if.row,
                    req_if.column, req_if.char_byte, req_if.last_char));
            if (rsp_if.valid && rsp_if.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 8'(rsp_if.status), '0);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", 8'(rsp_if.status), 8'(want.status));
                    if (rsp_if.lcd_rs !== want.pins.rs)
                        report_mismatch("lcd_rs", 8'(rsp_if.lcd_rs), 8'(want.pins.rs));
                    if (rsp_if.lcd_enable !== want.pins.en)
                        report_mismatch("lcd_enable", 8'(rsp_if.lcd_enable), 8'(want.pins.en));
                    if (rsp_if.lcd_data !== want.pins.data)
                        report_mismatch("lcd_data", rsp_if.lcd_data, want.pins.data);
                    if (rsp_if.done_event !== want.done)
                        report_mismatch("done_event", 8'(rsp_if.done_event), 8'(want.done));
                end
            end
        end
    end

    // Watchdog: any beat on either channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result sink: random idling, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rsp_if.ready = 1'b0;
            rx_hold_left--;
        end else begin
            rsp_if.ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request source and config port
    // ------------------------------------------------------------------
    // Entered and left at a falling edge; valid stays high between back-to-back beats.
    task automatic send_req(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
            logic [COL_W-1:0] col, logic [CHAR_W-1:0] ch, logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     = 1'b1;
        req_if.command   = cmd;
        req_if.row       = row;
        req_if.column    = col;
        req_if.char_byte = ch;
        req_if.last_char = last;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // Tick beats carry random junk in the unused fields
    task automatic send_tick();
        send_req(CMD_TICK, ROW_W'($urandom), COL_W'($urandom), CHAR_W'($urandom),
                 1'($urandom));
    endtask

    // Next character of the running random string; lengths past STRING_MAX happen
    task automatic send_string_char();
        logic last;
        last = (str_pos + 1 >= str_target);
        send_req(CMD_CHAR, ROW_W'($urandom), COL_W'($urandom), CHAR_W'($urandom), last);
        if (last) begin
            str_pos    = 0;
            str_target = $urandom_range(1, STRING_MAX + 4);
        end else begin
            str_pos++;
        end
    endtask

    // Tick until the model has nothing runnable at the read pointer
    task automatic drain_ring();
        int guard;
        guard = 0;
        while ((lcd_mode == MODE_INIT || (lcd_mode == MODE_OPER && slot_busy[rd_ptr]))
               && guard < 4 * RING_DEPTH + 40) begin
            send_tick();
            guard++;
        end
    endtask

    // Idle point: all results back, then a settling wait for the pipeline to empty
    task automatic settle();
        req_if.valid = 1'b0;
        while (awaited_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_AW'(int'(idx) * REG_STRIDE);
        pwdata  = CFG_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_TICK_PERIOD)
            tick_ms = value;
        else
            wait_ms = value;
    endtask

    // Mostly well-formed traffic: ticks, strings, positions and clears, with a
    // sprinkle of re-inits, spare commands, bad positions and ring-filling bursts.
    task automatic random_traffic(int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_tick();
            end else if (pick < 79) begin
                send_string_char();
            end else if (pick < 87) begin
                if ($urandom_range(0, 9) == 0)
                    send_req(CMD_POS, ROW_W'($urandom), COL_W'($urandom), CHAR_W'($urandom),
                             1'($urandom));
                else
                    send_req(CMD_POS, ROW_W'($urandom_range(0, ROW_MAX_OK)),
                             COL_W'($urandom_range(0, MAX_COLUMN)), CHAR_W'($urandom),
                             1'($urandom));
            end else if (pick < 93) begin
                send_req(CMD_CLEAR, ROW_W'($urandom), COL_W'($urandom), CHAR_W'($urandom),
                         1'($urandom));
            end else if (pick < 95) begin
                send_req(CMD_INIT, ROW_W'($urandom), COL_W'($urandom), CHAR_W'($urandom),
                         1'($urandom));
            end else if (pick < 97) begin
                send_req(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), ROW_W'($urandom),
                         COL_W'($urandom), CHAR_W'($urandom), 1'($urandom));
            end else begin
                // burst with no ticks: overflows the ring and runs strings long
                repeat (RING_DEPTH + 2) send_string_char();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Before any init: ticks and spare commands do nothing, bad positions are
    // rejected, requests queue. Every slot gets written here so that a slot
    // claimed later by an init request always holds a defined entry.
    task automatic test_inactive_queue();
        send_tick();
        send_req(CMD_SPARE_LO, '0, '0, '0, 1'b0);
        send_req(CMD_SPARE_HI, '1, '1, '1, 1'b1);
        send_req(CMD_POS, 2'd2, 5'd0, '0, 1'b0);
        send_req(CMD_POS, 2'd0, 5'd17, '0, 1'b0);
        send_req(CMD_POS, 2'd3, 5'd31, '0, 1'b0);
        send_req(CMD_CLEAR, '0, '0, '0, 1'b0);
        send_req(CMD_POS, 2'd0, 5'd0, '0, 1'b0);
        send_req(CMD_POS, 2'd1, MAX_COLUMN, '0, 1'b0);
        for (int k = 0; k < RING_DEPTH - 3; k++)
            send_req(CMD_CHAR, '0, '0, CHAR_W'(k * 19), k == RING_DEPTH - 4);
        // ring is full now: dropped
        send_req(CMD_CLEAR, '0, '0, '0, 1'b0);
    endtask

    // First init at the reset register values: power-on wait, four bytes, done
    task automatic test_power_up();
        send_req(CMD_INIT, '0, '0, '0, 1'b0);
        drain_ring();
    endtask

    task automatic test_requests();
        send_req(CMD_CLEAR, '1, '1, '1, 1'b1);
        send_req(CMD_POS, 2'd0, 5'd0, '1, 1'b1);
        send_req(CMD_POS, 2'd1, MAX_COLUMN, '0, 1'b0);
        send_req(CMD_POS, 2'd1, 5'd0, '0, 1'b0);
        send_req(CMD_CHAR, '1, '1, 8'hFF, 1'b0);
        send_req(CMD_CHAR, '0, '0, 8'h00, 1'b1);
        drain_ring();
    endtask

    // Sixteen characters fill the ring; the seventeenth is over length and, being
    // last, closes the string; a clear then finds the ring full.
    task automatic test_long_string();
        for (int k = 0; k < STRING_MAX; k++)
            send_req(CMD_CHAR, '0, '0, CHAR_W'(8'h41 + k), 1'b0);
        send_req(CMD_CHAR, '0, '0, 8'h5A, 1'b1);
        send_req(CMD_CLEAR, '0, '0, '0, 1'b0);
        drain_ring();
        send_req(CMD_CHAR, '0, '0, 8'h21, 1'b1);
        drain_ring();
    endtask

    // Second init: step counter is not rewound, so done on the first tick;
    // a clear queued during init runs afterwards.
    task automatic test_reinit();
        send_req(CMD_INIT, '0, '0, '0, 1'b0);
        send_req(CMD_CLEAR, '0, '0, '0, 1'b0);
        send_tick();
        drain_ring();
    endtask

    task automatic test_random_phase(int tx_pct, int rx_pct, logic [7:0] tick_val,
            logic [7:0] wait_val);
        settle();
        apb_write(REG_TICK_PERIOD, tick_val);
        apb_write(REG_POWER_WAIT, wait_val);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        random_traffic(ITEMS_PER_PHASE);
        drain_ring();
    endtask

    // Sink stalls for a long stretch while the source keeps offering beats,
    // so the result buffer fills and request ready drops.
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = HOLD_CYCLES;
        random_traffic(24);
        drain_ring();
    endtask

    initial begin
        req_if.valid     = 1'b0;
        req_if.command   = CMD_TICK;
        req_if.row       = '0;
        req_if.column    = '0;
        req_if.char_byte = '0;
        req_if.last_char = 1'b0;
        rsp_if.ready     = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part runs with the first idling mix
        tx_idle_pct = 21;
        rx_idle_pct = 76;
        test_inactive_queue();
        test_power_up();
        test_requests();
        test_long_string();
        test_reinit();

        test_random_phase(21, 76, 8'd1, 8'd255);
        test_random_phase(76, 21, 8'd255, 8'd1);
        test_backpressure();
        test_random_phase(0, 0, 8'd37, 8'd100);

        settle();
        repeat (END_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
